@@ sv/bloom_glow_pixel_filter_top_defines.svh @@
// assertion macros of the bloom glow filter checker
`ifndef BLOOM_GLOW_PIXEL_FILTER_TOP_DEFINES_SVH
`define BLOOM_GLOW_PIXEL_FILTER_TOP_DEFINES_SVH

// antecedent in one cycle implies consequent in the next, quiet during reset
`define BGF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bgf: next-cycle check failed");

// reset sampled low implies consequent in the next cycle
`define BGF_ASSERT_AFTER_RESET(label, clk, rst_n, cons) \
    label: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
        else $error("bgf: post-reset check failed");

`endif

@@ sv/bgf_pkg.sv @@
// constants, code tables and table builders of the bloom glow filter
`default_nettype none
package bgf_pkg;

    localparam int KERNEL_EXTENT_DEF = 8;
    localparam int MAX_WIDTH_DEF     = 1024;
    localparam int MAX_HEIGHT        = 4096;
    localparam int ROW_W             = 13;
    localparam int LIN_ONE           = 4096;
    localparam int THRESH            = 3686;
    localparam int GLOW_GAIN         = 10;
    localparam int LIN_SAT           = 65535;
    localparam int EX_W              = 9;
    localparam int BASE_W            = 12;
    localparam int KW_W              = 17;

    // register indexes
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_BORDER_SIZE  = 2'd2;

    typedef logic [255:0][12:0] t_dec_rom;
    typedef logic [255:0][13:0] t_mid_rom;

    // shift and subtract long division for the table builders
    function automatic longint unsigned udiv64(longint unsigned n, longint unsigned dv);
        longint unsigned q;
        longint unsigned rem;
        q   = 0;
        rem = 0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], n[i]};
            if (rem >= dv) begin
                rem  = rem - dv;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic longint unsigned pow5_q30(longint unsigned r);
        longint unsigned p;
        p = r;
        for (int i = 0; i < 4; i++) begin
            p = (p * r) >> 30;
        end
        return p;
    endfunction

    function automatic t_dec_rom build_dec();
        t_dec_rom        rom;
        longint unsigned t;
        longint unsigned s;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned l;
        for (int k = 0; k < 256; k++) begin
            if (k <= 10) begin
                rom[k] = 13'(udiv64(longint'(k) * 819200 + 329460, 658920));
            end else begin
                t  = udiv64(longint'(1000 * k + 14025) << 30, 269025);
                s  = (t * t) >> 30;
                lo = 0;
                hi = 64'd1 << 30;
                while (lo < hi) begin
                    mid = (lo + hi + 1) >> 1;
                    if (pow5_q30(mid) <= s) lo = mid;
                    else hi = mid - 1;
                end
                l      = (s * lo) >> 30;
                rom[k] = 13'((l * 4096 + (64'd1 << 29)) >> 30);
            end
        end
        return rom;
    endfunction

    localparam t_dec_rom DEC_ROM = build_dec();

    // midpoints between neighbouring codes, doubled
    function automatic t_mid_rom build_mid();
        t_mid_rom rom;
        rom[0] = '0;
        for (int k = 1; k < 256; k++) begin
            rom[k] = 14'(DEC_ROM[k-1]) + 14'(DEC_ROM[k]);
        end
        return rom;
    endfunction

    localparam t_mid_rom MID_ROM = build_mid();

    function automatic longint unsigned isqrt64(longint unsigned v_in);
        longint unsigned v;
        longint unsigned res;
        longint unsigned bitv;
        v    = v_in;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // radial falloff weight in q16
    function automatic logic [KW_W-1:0] kern_w(int x, int y, int k);
        longint unsigned r2;
        longint unsigned d;
        longint unsigned inv;
        longint unsigned f;
        longint unsigned span;
        r2   = longint'(x * x + y * y);
        d    = 65536 + ((3 * isqrt64(r2 << 32)) >> 1);
        inv  = udiv64(64'd1 << 48, d * d);
        span = longint'(k - 1) << 16;
        f    = 0;
        if (d < span) begin
            f = udiv64(5 * (span - d), longint'(k - 1));
            if (f > 65536) f = 65536;
        end
        return KW_W'((inv * f + 32768) >> 16);
    endfunction

endpackage
`default_nettype wire

@@ sv/bgf_ram.sv @@
// generic simple dual port ram with registered read
`default_nettype none
module bgf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

@@ sv/bgf_encode.sv @@
// linear to srgb byte, binary search over the code midpoints
`default_nettype none
module bgf_encode (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [12:0] i_value,
    output logic             o_done,
    output logic [7:0]       o_code
);
    logic        r_busy;
    logic        r_done;
    logic [2:0]  r_step;
    logic [7:0]  r_code;
    logic [13:0] r_val2;
    logic [7:0]  w_try;

    assign w_try = r_code | (8'd1 << (3'd7 - r_step));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && r_busy && r_step == 3'd7;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_code <= '0;
                r_val2 <= {i_value, 1'b0};
            end else if (r_busy) begin
                if (bgf_pkg::MID_ROM[w_try] <= r_val2) begin
                    r_code <= w_try;
                end
                r_step <= r_step + 3'd1;
                if (r_step == 3'd7) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_code = r_code;
endmodule
`default_nettype wire

@@ sv/bloom_glow_pixel_filter_top.sv @@
// bloom glow filter: line stores, kernel gather, spill and srgb encode
//
// input: bgra pixels in raster order on the slave stream, one request per
//   pixel; tuser marks a padding item. after a frame of width*height pixels,
//   width*KERNEL_EXTENT padding items drain the remaining output rows.
// output: one pixel per input item once KERNEL_EXTENT rows have gone in,
//   i.e. output pixel (x, y) leaves with input item (x, y+KERNEL_EXTENT);
//   tlast flags the last pixel of the frame, after which counters restart.
// rate: an item that produces no pixel is only written to the line stores;
//   for one that produces a pixel, the emissive line store read port sets
//   the pace, one tap per cycle across a (2*KERNEL_EXTENT-1)-wide square.
// one item is worked on at a time; a finished pixel sits in the output
//   register, so the next item is taken while the receiver stalls. only when
//   a second pixel is ready before the first was taken does the block wait.
// configuration writes (frame size, border) restart the frame; they are to
//   be taken only when idle, which the block itself does not enforce. reset
//   clears the counters and the output register; the line stores need no
//   clearing, as every entry is written before it is read.
`default_nettype none
module bloom_glow_pixel_filter_top #(
    parameter int KERNEL_EXTENT = bgf_pkg::KERNEL_EXTENT_DEF,
    parameter int MAX_WIDTH     = bgf_pkg::MAX_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // pixel request in
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // blue_in, green_in, red_in, alpha_in
    input  wire logic        i_s_tuser,   // is_padding
    // pixel request out
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // blue_out, green_out, red_out, alpha_out
    output logic             o_m_tlast,   // frame_last
    // register writes
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [12:0] i_cfg_data
);
    localparam int K       = KERNEL_EXTENT;
    localparam int SPAN    = 2 * K - 1;
    localparam int EM_ROWS = 2 * K;
    localparam int BA_ROWS = K + 1;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int WID_W   = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W   = bgf_pkg::ROW_W;
    localparam int EM_AW   = $clog2(EM_ROWS * MAX_WIDTH);
    localparam int BA_AW   = $clog2(BA_ROWS * MAX_WIDTH);
    localparam int ESL_W   = $clog2(EM_ROWS);
    localparam int BSL_W   = $clog2(BA_ROWS);
    localparam int TI_W    = $clog2(SPAN);
    localparam int KI_W    = $clog2(K * K);
    localparam int NX_W    = COL_W + 7;
    localparam int NY_W    = ROW_W + 7;
    localparam int AREA_W  = $clog2(MAX_WIDTH * bgf_pkg::MAX_HEIGHT + 1);
    localparam int EX_W    = bgf_pkg::EX_W;
    localparam int BASE_W  = bgf_pkg::BASE_W;
    localparam int KW_W    = bgf_pkg::KW_W;
    localparam int PR_W    = EX_W + KW_W;
    localparam int ACC_W   = $clog2(SPAN * SPAN) + PR_W;
    localparam int GS_W    = ACC_W + 5;
    localparam int EM_DW   = 3 * EX_W;
    localparam int BA_DW   = 3 * BASE_W + 8;
    localparam int CMP_W   = 15;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_WRITE  = 4'd1;
    localparam logic [3:0] S_GATHER = 4'd2;
    localparam logic [3:0] S_FLUSH  = 4'd3;
    localparam logic [3:0] S_GLOW   = 4'd4;
    localparam logic [3:0] S_SPILL  = 4'd5;
    localparam logic [3:0] S_MIX    = 4'd6;
    localparam logic [3:0] S_ENC    = 4'd7;
    localparam logic [3:0] S_LOAD   = 4'd8;

    logic [3:0]        r_state;
    // configuration and derived frame size
    logic [10:0]       r_fw;
    logic [12:0]       r_fh;
    logic [7:0]        r_bs;
    logic [WID_W-1:0]  r_w;
    logic [12:0]       r_h;
    logic [AREA_W-1:0] r_area_m1;
    // frame position
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [AREA_W-1:0] r_oi;
    logic [ESL_W-1:0]  r_em_slot;
    logic [BSL_W-1:0]  r_ba_slot;
    // current item
    logic [31:0]       r_pix;
    logic              r_pad;
    // tap walk
    logic [TI_W-1:0]   r_ti;
    logic [TI_W-1:0]   r_tj;
    logic [ESL_W-1:0]  r_tslot;
    logic              r_p0_v;
    logic [KW_W-1:0]   r_p0_w;
    logic              r_p1_v;
    logic [PR_W-1:0]   r_prod [3];
    logic [ACC_W-1:0]  r_acc [3];
    logic              r_flush;
    // post processing
    logic [15:0]       r_lin [3];
    logic [17:0]       r_spill;
    logic [7:0]        r_alpha;
    // output register
    logic              r_out_v;
    logic [31:0]       r_out_data;
    logic              r_out_last;

    logic [KW_W-1:0]   w_kern [K*K];

    // derived frame size
    logic [WID_W-1:0]  n_w;
    logic [12:0]       n_h;
    logic              w_cfg_hit;

    always_comb begin
        if (r_fw == '0) n_w = WID_W'(1);
        else if (32'(r_fw) > MAX_WIDTH) n_w = WID_W'(MAX_WIDTH);
        else n_w = WID_W'(r_fw);
        if (r_fh == '0) n_h = 13'd1;
        else if (32'(r_fh) > bgf_pkg::MAX_HEIGHT) n_h = 13'(bgf_pkg::MAX_HEIGHT);
        else n_h = r_fh;
    end

    assign w_cfg_hit = i_cfg_we && (i_cfg_idx == bgf_pkg::CFG_FRAME_WIDTH
                                 || i_cfg_idx == bgf_pkg::CFG_FRAME_HEIGHT
                                 || i_cfg_idx == bgf_pkg::CFG_BORDER_SIZE);

    // kernel weights, built at elaboration
    for (genvar gx = 0; gx < K; gx++) begin : g_kx
        for (genvar gy = 0; gy < K; gy++) begin : g_ky
            assign w_kern[gx*K+gy] = bgf_pkg::kern_w(gx, gy, K);
        end
    end

    // write side: decode, threshold split
    logic              w_interior;
    logic              w_in_frame;
    logic              w_emit;
    logic [12:0]       w_lin [3];
    logic [EM_DW-1:0]  w_em_wdata;
    logic [BA_DW-1:0]  w_ba_wdata;
    logic [EM_AW-1:0]  w_em_waddr;
    logic [BA_AW-1:0]  w_ba_waddr;
    logic [BA_AW-1:0]  w_ba_raddr;
    logic [BSL_W-1:0]  w_ba_rslot;

    assign w_interior = CMP_W'(r_col) >= CMP_W'(r_bs)
                     && CMP_W'(r_col) + CMP_W'(r_bs) < CMP_W'(r_w)
                     && CMP_W'(r_row) >= CMP_W'(r_bs)
                     && CMP_W'(r_row) + CMP_W'(r_bs) < CMP_W'(r_h);
    assign w_in_frame = CMP_W'(r_row) < CMP_W'(r_h);
    assign w_emit     = CMP_W'(r_row) >= CMP_W'(K);

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            if (r_pad || !w_interior) w_lin[ch] = '0;
            else w_lin[ch] = bgf_pkg::DEC_ROM[r_pix[ch*8 +: 8]];
            if (w_lin[ch] > 13'(bgf_pkg::THRESH)) begin
                w_em_wdata[ch*EX_W +: EX_W]     = EX_W'(w_lin[ch] - 13'(bgf_pkg::THRESH));
                w_ba_wdata[ch*BASE_W +: BASE_W] = BASE_W'(bgf_pkg::THRESH);
            end else begin
                w_em_wdata[ch*EX_W +: EX_W]     = '0;
                w_ba_wdata[ch*BASE_W +: BASE_W] = BASE_W'(w_lin[ch]);
            end
        end
        w_ba_wdata[3*BASE_W +: 8] = r_pad ? 8'd0 : r_pix[31:24];
    end

    assign w_em_waddr = EM_AW'(r_em_slot) * EM_AW'(MAX_WIDTH) + EM_AW'(r_col);
    assign w_ba_waddr = BA_AW'(r_ba_slot) * BA_AW'(MAX_WIDTH) + BA_AW'(r_col);
    // output row is KERNEL_EXTENT rows back, one slot ahead in the ring
    assign w_ba_rslot = (r_ba_slot == BSL_W'(BA_ROWS - 1)) ? '0 : r_ba_slot + BSL_W'(1);
    assign w_ba_raddr = BA_AW'(w_ba_rslot) * BA_AW'(MAX_WIDTH) + BA_AW'(r_col);

    // tap walk: neighbour position, bounds and weight
    logic [NX_W-1:0]   w_nx;
    logic [NY_W-1:0]   w_ny;
    logic              w_tap_ok;
    logic [EM_AW-1:0]  w_em_raddr;
    logic [TI_W-1:0]   w_adx;
    logic [TI_W-1:0]   w_ady;
    logic [KI_W-1:0]   w_kidx;
    logic              w_ti_end;
    logic              w_tj_end;
    logic [ESL_W-1:0]  w_tslot_nx;
    logic [ESL_W-1:0]  w_tslot_init;

    assign w_nx = NX_W'(r_col) + NX_W'(r_ti) - NX_W'(K - 1);
    assign w_ny = NY_W'(r_row) + NY_W'(r_tj) - NY_W'(SPAN);
    assign w_tap_ok = !w_nx[NX_W-1] && w_nx < NX_W'(r_w)
                   && !w_ny[NY_W-1] && w_ny < NY_W'(r_h);
    assign w_em_raddr = EM_AW'(r_tslot) * EM_AW'(MAX_WIDTH) + EM_AW'(w_nx[COL_W-1:0]);
    assign w_adx = (r_ti >= TI_W'(K - 1)) ? r_ti - TI_W'(K - 1) : TI_W'(K - 1) - r_ti;
    assign w_ady = (r_tj >= TI_W'(K - 1)) ? r_tj - TI_W'(K - 1) : TI_W'(K - 1) - r_tj;
    assign w_kidx = KI_W'(w_adx) * KI_W'(K) + KI_W'(w_ady);
    assign w_ti_end = r_ti == TI_W'(SPAN - 1);
    assign w_tj_end = r_tj == TI_W'(SPAN - 1);
    assign w_tslot_nx   = (r_tslot == ESL_W'(EM_ROWS - 1)) ? '0 : r_tslot + ESL_W'(1);
    assign w_tslot_init = (r_em_slot == ESL_W'(EM_ROWS - 1)) ? '0 : r_em_slot + ESL_W'(1);

    // line stores
    logic [EM_DW-1:0] w_em_rdata;
    logic [BA_DW-1:0] w_ba_rdata;

    bgf_ram #(.WIDTH(EM_DW), .DEPTH(EM_ROWS * MAX_WIDTH)) u_em_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_WRITE && w_in_frame),
        .i_waddr (w_em_waddr),
        .i_wdata (w_em_wdata),
        .i_re    (r_state == S_GATHER),
        .i_raddr (w_em_raddr),
        .o_rdata (w_em_rdata)
    );

    bgf_ram #(.WIDTH(BA_DW), .DEPTH(BA_ROWS * MAX_WIDTH)) u_ba_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_WRITE && w_in_frame),
        .i_waddr (w_ba_waddr),
        .i_wdata (w_ba_wdata),
        .i_re    (r_state == S_WRITE && w_emit),
        .i_raddr (w_ba_raddr),
        .o_rdata (w_ba_rdata)
    );

    // glow, saturate, spill
    logic [GS_W-1:0]  w_gsum [3];
    logic [GS_W-1:0]  w_v [3];
    logic [15:0]      w_sat [3];
    logic [17:0]      w_spill;
    logic [15:0]      w_clip [3];
    logic [17:0]      w_mixed [3];
    logic [12:0]      w_enc_in [3];

    always_comb begin
        w_spill = '0;
        for (int ch = 0; ch < 3; ch++) begin
            w_gsum[ch] = GS_W'(r_acc[ch]) * GS_W'(bgf_pkg::GLOW_GAIN) + GS_W'(32768);
            w_v[ch]    = GS_W'(w_ba_rdata[ch*BASE_W +: BASE_W]) + (w_gsum[ch] >> 16);
            w_sat[ch]  = (w_v[ch] > GS_W'(bgf_pkg::LIN_SAT)) ? 16'(bgf_pkg::LIN_SAT)
                                                            : w_v[ch][15:0];
            if (r_lin[ch] > 16'(bgf_pkg::LIN_ONE)) begin
                w_spill    = w_spill + 18'(r_lin[ch] - 16'(bgf_pkg::LIN_ONE));
                w_clip[ch] = 16'(bgf_pkg::LIN_ONE);
            end else begin
                w_clip[ch] = r_lin[ch];
            end
            w_mixed[ch] = 18'(r_lin[ch]) + (r_spill >> 1);
            if (r_spill != '0 && w_mixed[ch] > 18'(bgf_pkg::LIN_ONE)) begin
                w_enc_in[ch] = 13'(bgf_pkg::LIN_ONE);
            end else if (r_spill != '0) begin
                w_enc_in[ch] = w_mixed[ch][12:0];
            end else begin
                w_enc_in[ch] = r_lin[ch][12:0];
            end
        end
    end

    // encoders, one per colour
    logic       w_enc_done [3];
    logic [7:0] w_code [3];

    for (genvar gc = 0; gc < 3; gc++) begin : g_enc
        bgf_encode u_enc (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (r_state == S_MIX),
            .i_value (w_enc_in[gc]),
            .o_done  (w_enc_done[gc]),
            .o_code  (w_code[gc])
        );
    end

    // position advance at the end of an item
    logic              w_last;
    logic              w_col_wrap;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  n_row;
    logic [ESL_W-1:0]  n_em_slot;
    logic [BSL_W-1:0]  n_ba_slot;
    logic              w_can_load;

    assign w_last     = r_oi >= r_area_m1;
    assign w_col_wrap = (COL_W+1)'(r_col) + (COL_W+1)'(1) >= (COL_W+1)'(r_w);
    assign w_can_load = !r_out_v || i_m_tready;

    always_comb begin
        n_col     = r_col + COL_W'(1);
        n_row     = r_row;
        n_em_slot = r_em_slot;
        n_ba_slot = r_ba_slot;
        if (w_col_wrap) begin
            n_col     = '0;
            n_row     = r_row + ROW_W'(1);
            n_em_slot = (r_em_slot == ESL_W'(EM_ROWS - 1)) ? '0 : r_em_slot + ESL_W'(1);
            n_ba_slot = (r_ba_slot == BSL_W'(BA_ROWS - 1)) ? '0 : r_ba_slot + BSL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fw      <= 11'd1024;
            r_fh      <= 13'd1024;
            r_bs      <= 8'd8;
            r_col     <= '0;
            r_row     <= '0;
            r_oi      <= '0;
            r_em_slot <= '0;
            r_ba_slot <= '0;
            r_p0_v    <= 1'b0;
            r_p1_v    <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            // tap valid follows the gather walk
            r_p0_v <= (r_state == S_GATHER) && w_tap_ok;
            r_p1_v <= r_p0_v;
            // the load state refills the register itself
            if (r_out_v && i_m_tready && r_state != S_LOAD) begin
                r_out_v <= 1'b0;
            end

            if (w_cfg_hit) begin
                unique case (i_cfg_idx)
                    bgf_pkg::CFG_FRAME_WIDTH:  r_fw <= i_cfg_data[10:0];
                    bgf_pkg::CFG_FRAME_HEIGHT: r_fh <= i_cfg_data;
                    bgf_pkg::CFG_BORDER_SIZE:  r_bs <= i_cfg_data[7:0];
                    default:                   r_bs <= r_bs;
                endcase
                r_col     <= '0;
                r_row     <= '0;
                r_oi      <= '0;
                r_em_slot <= '0;
                r_ba_slot <= '0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_pix   <= i_s_tdata;
                        r_pad   <= i_s_tuser;
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (w_emit) begin
                        r_ti    <= '0;
                        r_tj    <= '0;
                        r_tslot <= w_tslot_init;
                        r_state <= S_GATHER;
                    end else begin
                        r_col     <= n_col;
                        r_row     <= n_row;
                        r_em_slot <= n_em_slot;
                        r_ba_slot <= n_ba_slot;
                        r_state   <= S_IDLE;
                    end
                end
                S_GATHER: begin
                    r_p0_w <= w_kern[w_kidx];
                    if (w_ti_end) begin
                        r_ti    <= '0;
                        r_tj    <= r_tj + TI_W'(1);
                        r_tslot <= w_tslot_nx;
                    end else begin
                        r_ti <= r_ti + TI_W'(1);
                    end
                    if (w_ti_end && w_tj_end) begin
                        r_flush <= 1'b0;
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    r_flush <= 1'b1;
                    if (r_flush) r_state <= S_GLOW;
                end
                S_GLOW: begin
                    for (int ch = 0; ch < 3; ch++) r_lin[ch] <= w_sat[ch];
                    r_alpha <= w_ba_rdata[3*BASE_W +: 8];
                    r_state <= S_SPILL;
                end
                S_SPILL: begin
                    for (int ch = 0; ch < 3; ch++) r_lin[ch] <= w_clip[ch];
                    r_spill <= w_spill;
                    r_state <= S_MIX;
                end
                S_MIX: begin
                    r_state <= S_ENC;
                end
                S_ENC: begin
                    if (w_enc_done[0]) r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (w_can_load) begin
                        r_out_v    <= 1'b1;
                        r_out_data <= {r_alpha, w_code[2], w_code[1], w_code[0]};
                        r_out_last <= w_last;
                        if (w_last) begin
                            r_col     <= '0;
                            r_row     <= '0;
                            r_oi      <= '0;
                            r_em_slot <= '0;
                            r_ba_slot <= '0;
                        end else begin
                            r_oi      <= r_oi + AREA_W'(1);
                            r_col     <= n_col;
                            r_row     <= n_row;
                            r_em_slot <= n_em_slot;
                            r_ba_slot <= n_ba_slot;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // multiply and accumulate lanes, two stages behind the tap address
    always_ff @(posedge i_clk) begin
        for (int ch = 0; ch < 3; ch++) begin
            r_prod[ch] <= PR_W'(w_em_rdata[ch*EX_W +: EX_W]) * PR_W'(r_p0_w);
            if (r_state == S_WRITE) r_acc[ch] <= '0;
            else if (r_p1_v) r_acc[ch] <= r_acc[ch] + ACC_W'(r_prod[ch]);
        end
    end

    // frame size pipeline: clamped width and height, then area minus one
    always_ff @(posedge i_clk) begin
        r_w       <= n_w;
        r_h       <= n_h;
        r_area_m1 <= AREA_W'(AREA_W'(r_w) * AREA_W'(r_h) - AREA_W'(1));
    end

    assign o_s_tready = r_state == S_IDLE;
    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
endmodule
`default_nettype wire

@@ sv/bgf_checker.sv @@
// port level checks of the bloom glow filter, bound to the top level
`default_nettype none
`include "bloom_glow_pixel_filter_top_defines.svh"
module bgf_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [31:0] o_m_tdata,
    input wire logic        o_m_tlast
);
    // an accepted request always leaves the block not ready in the next cycle
    `BGF_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)

    // a stalled result holds its pixel and frame flag
    `BGF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))

    // reset leaves the block empty and ready
    `BGF_ASSERT_AFTER_RESET(a_reset_idle, i_clk, i_rst_n, !o_m_tvalid && o_s_tready)
endmodule

bind bloom_glow_pixel_filter_top bgf_checker u_bgf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
`default_nettype wire
